/* rtl/assert_macros.svh */
// Assertion macros used by the top level of the block decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   `ASSERT_CLK(label, clk, rst, !(cond), msg)

`endif

/* rtl/etc1bd_pkg.sv */
// Types, constants and the intensity modifier table of the ETC1 block decoder.
`timescale 1ns / 1ps

package etc1bd_pkg;

   localparam int MaxImageDim       = 4096;
   localparam int QueueDepthDefault = 2;
   localparam int CsrAddrWidth      = 3;
   localparam logic [12:0] DimReset = 13'd4096;

   typedef enum logic {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [63:0] block_word;
      logic [9:0]  block_col;
      logic [9:0]  block_row;
   } req_type;

   typedef struct packed {
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        last;
   } rsp_type;

   // One decoded block as it waits between front and back end.
   typedef struct packed {
      logic [1:0][2:0][7:0] base;       // [half][channel], expanded to 8 bits
      logic [1:0][2:0]      table_sel;  // intensity table row of each half
      logic                 flip;
      logic [15:0]          msb_bits;   // per-pixel modifier index, high bit
      logic [15:0]          lsb_bits;   // per-pixel modifier index, low bit
      logic [15:0]          pix_mask;   // pixels that lie inside the image
      logic [9:0]           block_col;
      logic [9:0]           block_row;
   } blk_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_stat_type;

   // Signed modifier for one pixel: the high index bit negates, the low one
   // picks the large magnitude.
   function automatic logic signed [8:0] mod_value(input logic [2:0] sel,
                                                   input logic msb,
                                                   input logic lsb);
      logic [7:0] mag;
      case (sel)
         3'd0: mag = lsb ? 8'd8   : 8'd2;
         3'd1: mag = lsb ? 8'd17  : 8'd5;
         3'd2: mag = lsb ? 8'd29  : 8'd9;
         3'd3: mag = lsb ? 8'd42  : 8'd13;
         3'd4: mag = lsb ? 8'd60  : 8'd18;
         3'd5: mag = lsb ? 8'd80  : 8'd24;
         3'd6: mag = lsb ? 8'd106 : 8'd33;
         3'd7: mag = lsb ? 8'd183 : 8'd47;
         default: mag = 8'd0;
      endcase
      mod_value = msb ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

endpackage

/* rtl/etc1bd_front.sv */
// Front end: request handshake, block field decode and image-bounds mask.
`timescale 1ns / 1ps

module etc1bd_front (
   input  logic                   start,
   output logic                   busy,
   input  etc1bd_pkg::req_type    req_data,
   input  logic [12:0]            width_lim,
   input  logic [12:0]            height_lim,
   input  etc1bd_pkg::q_stat_type q_stat,
   output logic                   q_push,
   output etc1bd_pkg::blk_type    q_data
);
   import etc1bd_pkg::*;

   logic [7:0]           byte_k [8];
   logic                 diff_mode;
   logic [2:0][4:0]      diff_sum;
   logic [3:0]           col_ok;
   logic [3:0]           row_ok;

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         byte_k[k] = req_data.block_word[63 - 8 * k -: 8];
      end
   end

   assign diff_mode = byte_k[3][1];

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         diff_sum[ch] = byte_k[ch][7:3] + {{2{byte_k[ch][2]}}, byte_k[ch][2:0]};
         if (diff_mode) begin
            q_data.base[0][ch] = {byte_k[ch][7:3], byte_k[ch][7:5]};
            q_data.base[1][ch] = {diff_sum[ch], diff_sum[ch][4:2]};
         end else begin
            q_data.base[0][ch] = {byte_k[ch][7:4], byte_k[ch][7:4]};
            q_data.base[1][ch] = {byte_k[ch][3:0], byte_k[ch][3:0]};
         end
      end
   end

   // Column-major pixel order: bit 4*x + y of the mask is pixel (x, y).
   always_comb begin
      for (int o = 0; o < 4; o++) begin
         col_ok[o] = {1'b0, req_data.block_col, 2'(o)} < width_lim;
         row_ok[o] = {1'b0, req_data.block_row, 2'(o)} < height_lim;
      end
      for (int p = 0; p < 16; p++) begin
         q_data.pix_mask[p] = col_ok[p / 4] & row_ok[p % 4];
      end
   end

   assign q_data.table_sel[0] = byte_k[3][7:5];
   assign q_data.table_sel[1] = byte_k[3][4:2];
   assign q_data.flip         = byte_k[3][0];
   assign q_data.msb_bits     = {byte_k[4], byte_k[5]};
   assign q_data.lsb_bits     = {byte_k[6], byte_k[7]};
   assign q_data.block_col    = req_data.block_col;
   assign q_data.block_row    = req_data.block_row;

   // A block with no pixel inside the image is taken and dropped here.
   assign busy   = q_stat.full;
   assign q_push = start && !q_stat.full && (q_data.pix_mask != 16'd0);

endmodule

/* rtl/etc1bd_queue.sv */
// Small FIFO of decoded blocks between the front and back ends.
`timescale 1ns / 1ps

module etc1bd_queue #(
   parameter int DEPTH = etc1bd_pkg::QueueDepthDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  etc1bd_pkg::blk_type     push_data,
   input  logic                    pop,
   output etc1bd_pkg::blk_type     head_data,
   output etc1bd_pkg::q_stat_type  stat
);
   import etc1bd_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   blk_type         entry_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data      = entry_ff[rd_ptr_ff];
   assign stat.full      = (count_ff == CntW'(DEPTH));
   assign stat.not_empty = (count_ff != '0);

endmodule

/* rtl/etc1bd_back.sv */
// Back end: walks the inside pixels of one block and emits one per cycle.
`timescale 1ns / 1ps

module etc1bd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  etc1bd_pkg::q_stat_type q_stat,
   input  etc1bd_pkg::blk_type    q_head,
   output logic                   q_pop,
   output logic                   rsp_strobe,
   output etc1bd_pkg::rsp_type    rsp_data
);
   import etc1bd_pkg::*;

   function automatic logic [7:0] clamp_add(input logic [7:0] c,
                                            input logic signed [8:0] m);
      logic signed [9:0] s;
      s = $signed({2'b00, c}) + 10'(m);
      if (s < 0) begin
         clamp_add = 8'd0;
      end else if (s > 10'sd255) begin
         clamp_add = 8'd255;
      end else begin
         clamp_add = s[7:0];
      end
   endfunction

   blk_type           cur_ff, cur_in;
   logic [15:0]       rem_ff, rem_in;
   logic              strobe_ff;
   rsp_type           rsp_ff, rsp_in;
   logic              active;
   logic [3:0]        idx;
   logic [15:0]       rem_next;
   logic              is_last;
   logic              half;
   logic signed [8:0] mod;

   assign active = (rem_ff != 16'd0);

   // Lowest pending pixel goes next.
   always_comb begin
      idx = 4'd0;
      for (int p = 15; p >= 0; p--) begin
         if (rem_ff[p]) begin
            idx = 4'(p);
         end
      end
   end

   assign rem_next = rem_ff & ~(16'd1 << idx);
   assign is_last  = (rem_next == 16'd0);
   assign q_pop    = q_stat.not_empty && (!active || is_last);

   always_comb begin
      cur_in = cur_ff;
      rem_in = active ? rem_next : 16'd0;
      if (q_pop) begin
         cur_in = q_head;
         rem_in = q_head.pix_mask;
      end
   end

   always_comb begin
      half = cur_ff.flip ? idx[1] : idx[3];
      mod  = mod_value(cur_ff.table_sel[half], cur_ff.msb_bits[idx], cur_ff.lsb_bits[idx]);
      rsp_in.pixel_x = {cur_ff.block_col, idx[3:2]};
      rsp_in.pixel_y = {cur_ff.block_row, idx[1:0]};
      rsp_in.red     = clamp_add(cur_ff.base[half][0], mod);
      rsp_in.green   = clamp_add(cur_ff.base[half][1], mod);
      rsp_in.blue    = clamp_add(cur_ff.base[half][2], mod);
      rsp_in.last    = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff    <= 16'd0;
         strobe_ff <= 1'b0;
      end else begin
         rem_ff    <= rem_in;
         strobe_ff <= active;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (active) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* rtl/etc1_block_decoder_unit.sv */
// Top level of the ETC1 block decoder: register port, front end, queue, back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The ETC1 block decoder turns one 64-bit compressed block into its sixteen
// RGB888 pixels, column-major, and drops pixels outside the image size.
// A request is taken at a rising edge with start high and busy low; it carries
// the block word and the block column and row. A request whose pixels all lie
// outside the image is taken and yields nothing.
// Each pixel appears on rsp_data for exactly one cycle with rsp_strobe high,
// and last marks the final pixel of a block. The receiver cannot stall.
// An accepted block passes the queue, waiting there while the back end is
// busy, then the back end's block register; each pixel is registered out.
// The back end emits one pixel per cycle; queued blocks follow with no gap.
// The queue lets the front end take new requests while the back end works;
// busy is high while it is full. Image width and height sit at byte addresses
// 0 and 4 of the register port and reset to 4096; the user must write them
// only while idle, which the block does not enforce. Values above 4096 act
// as 4096 and zero hides every pixel. Reset empties the queue and back end.
module etc1_block_decoder_unit #(
   parameter int QUEUE_DEPTH = etc1bd_pkg::QueueDepthDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  etc1bd_pkg::req_type                 req_data,
   output logic                                rsp_strobe,
   output etc1bd_pkg::rsp_type                 rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [etc1bd_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import etc1bd_pkg::*;

   logic [12:0]   width_ff, width_in;
   logic [12:0]   height_ff, height_in;
   logic [12:0]   width_lim;
   logic [12:0]   height_lim;
   logic          csr_write;
   csr_index_type csr_index;
   q_stat_type    q_stat;
   logic          q_push;
   logic          q_pop;
   blk_type       q_in_data;
   blk_type       q_head;

   // Register port: zero wait states, one register per word.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = csr_index_type'(paddr[2]);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = pwdata[12:0];
            CSR_IMAGE_HEIGHT: height_in = pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DimReset;
         height_ff <= DimReset;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      case (csr_index)
         CSR_IMAGE_WIDTH:  prdata = {19'd0, width_ff};
         CSR_IMAGE_HEIGHT: prdata = {19'd0, height_ff};
         default:          prdata = 32'd0;
      endcase
   end

   // Sizes above the supported maximum behave as the maximum.
   assign width_lim  = (int'(width_ff) > MaxImageDim) ? 13'(MaxImageDim) : width_ff;
   assign height_lim = (int'(height_ff) > MaxImageDim) ? 13'(MaxImageDim) : height_ff;

   etc1bd_front u_front (
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .width_lim  (width_lim),
      .height_lim (height_lim),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_data     (q_in_data)
   );

   etc1bd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .head_data (q_head),
      .stat      (q_stat)
   );

   etc1bd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // The queue is never written while full nor read while empty, and it only
   // fills up through a write.
   `ASSERT_NEVER(a_push_full, clock, reset, q_push && q_stat.full, "push into full queue")
   `ASSERT_NEVER(a_pop_empty, clock, reset, q_pop && !q_stat.not_empty, "pop from empty queue")
   `ASSERT_CLK(a_busy_rise, clock, reset, $rose(busy) |-> $past(q_push), "busy rose without push")

endmodule

/* test/tb_etc1_block_decoder_unit.sv */
// Testbench of the ETC1 block decoder: directed block table, random blocks, pixel predictor.
`timescale 1ns / 1ps

module tb_etc1_block_decoder_unit;
   import etc1bd_pkg::*;

   // Clock cycles of quiet time after the last owed pixel, before the image
   // size is reprogrammed and before the run ends.
   localparam int SETTLE_CYCLES = 64;
   // Cycles without any accepted request, pixel or register access before the
   // run is declared hung.
   localparam int STALL_LIMIT   = 2000;

   // Modifier magnitudes of the eight intensity rows: the small one is used
   // when the low index bit is clear, the large one when it is set. The high
   // index bit makes the modifier negative.
   localparam int MOD_SMALL [8] = '{2, 5, 9, 13, 18, 24, 33, 47};
   localparam int MOD_LARGE [8] = '{8, 17, 29, 42, 60, 80, 106, 183};

   // One row of the directed part. A row with new_size set first reprograms
   // the image size. A row with typed set carries the number of pixels and the
   // single colour that every emitted pixel must have; the predictor still
   // supplies the pixel positions and the last flag.
   typedef struct packed {
      logic        new_size;
      logic [31:0] size_w;
      logic [31:0] size_h;
      logic [63:0] word;
      logic [9:0]  col;
      logic [9:0]  row;
      logic        typed;
      logic [4:0]  n_pix;
      logic [23:0] rgb;
   } block_case_type;

   localparam int NUM_DIRECTED = 22;
   localparam block_case_type DIRECTED [NUM_DIRECTED] = '{
      // All-zero block: individual mode, black bases, small positive modifier.
      '{1'b0, 32'd0, 32'd0, 64'h00000000_00000000, 10'd0, 10'd0, 1'b1, 5'd16, 24'h020202},
      // White individual bases with the large negative modifier of row 0.
      '{1'b0, 32'd0, 32'd0, 64'hFFFFFF00_FFFFFFFF, 10'd0, 10'd0, 1'b1, 5'd16, 24'hF7F7F7},
      // Clamp at the top: white plus 183.
      '{1'b0, 32'd0, 32'd0, 64'hFFFFFFFC_0000FFFF, 10'd5, 10'd9, 1'b1, 5'd16, 24'hFFFFFF},
      // Clamp at the bottom: black minus 183.
      '{1'b0, 32'd0, 32'd0, 64'h000000FC_FFFFFFFF, 10'd1023, 10'd0, 1'b1, 5'd16, 24'h000000},
      // Far corner of the largest image.
      '{1'b0, 32'd0, 32'd0, 64'h00000000_00000000, 10'd1023, 10'd1023, 1'b1, 5'd16, 24'h020202},
      '{1'b0, 32'd0, 32'd0, 64'hFFFFFFFF_FFFFFFFF, 10'd1023, 10'd1023, 1'b0, 5'd0, 24'h0},
      // Differential mode where base plus delta runs past 31 and below 0.
      '{1'b0, 32'd0, 32'd0, 64'hFB030402_A5C35A3C, 10'd7, 10'd3, 1'b0, 5'd0, 24'h0},
      '{1'b0, 32'd0, 32'd0, 64'hFB030403_69C3965A, 10'd8, 10'd3, 1'b0, 5'd0, 24'h0},
      // Individual and differential modes, both split directions, different rows per half.
      '{1'b0, 32'd0, 32'd0, 64'h1E2D3C8D_0F0FF0F0, 10'd2, 10'd1, 1'b0, 5'd0, 24'h0},
      '{1'b0, 32'd0, 32'd0, 64'h7B8A99E6_12345678, 10'd4, 10'd4, 1'b0, 5'd0, 24'h0},
      '{1'b0, 32'd0, 32'd0, 64'h55555555_AAAAAAAA, 10'd512, 10'd256, 1'b0, 5'd0, 24'h0},
      '{1'b0, 32'd0, 32'd0, 64'hAAAAAAAA_55555555, 10'd341, 10'd682, 1'b0, 5'd0, 24'h0},
      // Width 13 (junk above bit 12 in the write data) by height 6: partial
      // blocks, and blocks wholly outside that yield nothing.
      '{1'b1, 32'hFFFFE00D, 32'd6, 64'h00000000_00000000, 10'd3, 10'd1, 1'b1, 5'd2, 24'h020202},
      '{1'b0, 32'd0, 32'd0, 64'h00000000_00000000, 10'd4, 10'd0, 1'b1, 5'd0, 24'h0},
      '{1'b0, 32'd0, 32'd0, 64'h00000000_00000000, 10'd0, 10'd2, 1'b1, 5'd0, 24'h0},
      '{1'b0, 32'd0, 32'd0, 64'hFFFFFFFC_0000FFFF, 10'd0, 10'd0, 1'b1, 5'd16, 24'hFFFFFF},
      // A zero dimension hides every pixel.
      '{1'b1, 32'd0, 32'd4096, 64'h00000000_00000000, 10'd0, 10'd0, 1'b1, 5'd0, 24'h0},
      '{1'b1, 32'd4096, 32'd0, 64'h00000000_00000000, 10'd0, 10'd0, 1'b1, 5'd0, 24'h0},
      // Oversized dimensions act as the largest image.
      '{1'b1, 32'd8191, 32'd5000, 64'h00000000_00000000, 10'd1023, 10'd1023, 1'b1, 5'd16,
        24'h020202},
      // A one-pixel image.
      '{1'b1, 32'd1, 32'd1, 64'hFFFFFF00_FFFFFFFF, 10'd0, 10'd0, 1'b1, 5'd1, 24'hF7F7F7},
      '{1'b1, 32'd4095, 32'd4094, 64'h00000000_00000000, 10'd1023, 10'd1023, 1'b1, 5'd6,
        24'h020202},
      '{1'b1, 32'd4097, 32'd4097, 64'h00000000_00000000, 10'd1023, 10'd1023, 1'b1, 5'd16,
        24'h020202}
   };

   // Image sizes of the random phases and the number of blocks sent in each.
   localparam int NUM_PHASES = 7;
   localparam int PHASE_W [NUM_PHASES] = '{4096, 13, 4095, 8191, 100, 1, 0};
   localparam int PHASE_H [NUM_PHASES] = '{4096, 7, 4093, 8191, 37, 4096, 0};
   localparam int PHASE_N [NUM_PHASES] = '{50, 35, 30, 28, 35, 20, 10};

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // The image size as the block should hold it, and the pixels still owed by
   // the block, oldest first.
   logic [12:0] image_w;
   logic [12:0] image_h;
   rsp_type     pending_pixels [$];
   int          mismatch_count;

   etc1_block_decoder_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   // Decodes one block as the hardware should and appends the pixels that
   // fall inside the image to the pending list. Pixels walk the block column
   // by column; index bits of pixels 0..7 come from bytes 5 and 7, those of
   // pixels 8..15 from bytes 4 and 6.
   function automatic void decode_block(input req_type blk);
      logic [7:0] blk_byte [8];
      logic [7:0] raw [2];
      logic [7:0] base [2][3];
      logic [2:0] row_sel [2];
      logic [7:0] chan [3];
      logic       diff_mode;
      logic       flip;
      logic       hi;
      logic       lo;
      rsp_type    pix;
      int         wlim;
      int         hlim;
      int         xo;
      int         yo;
      int         half;
      int         modifier;
      int         level;
      int         px;
      int         py;
      int         emitted;

      for (int k = 0; k < 8; k++) begin
         blk_byte[k] = blk.block_word[63 - 8 * k -: 8];
      end
      diff_mode = blk_byte[3][1];
      flip      = blk_byte[3][0];
      for (int ch = 0; ch < 3; ch++) begin
         if (diff_mode) begin
            // The second base is the first plus a signed 3-bit delta, kept to
            // eight bits; both are widened from five bits by copying the top
            // three bits below.
            raw[0] = {3'b000, blk_byte[ch][7:3]};
            raw[1] = raw[0] + {{5{blk_byte[ch][2]}}, blk_byte[ch][2:0]};
            for (int h = 0; h < 2; h++) begin
               base[h][ch] = {raw[h][4:0], 3'b000} + {5'b00000, raw[h][4:2]};
            end
         end else begin
            base[0][ch] = {blk_byte[ch][7:4], blk_byte[ch][7:4]};
            base[1][ch] = {blk_byte[ch][3:0], blk_byte[ch][3:0]};
         end
      end
      row_sel[0] = blk_byte[3][7:5];
      row_sel[1] = blk_byte[3][4:2];

      wlim = (image_w > 13'd4096) ? 4096 : int'(image_w);
      hlim = (image_h > 13'd4096) ? 4096 : int'(image_h);
      emitted = 0;
      for (int i = 0; i < 16; i++) begin
         xo = i / 4;
         yo = i % 4;
         if (i < 8) begin
            hi = blk_byte[5][i];
            lo = blk_byte[7][i];
         end else begin
            hi = blk_byte[4][i - 8];
            lo = blk_byte[6][i - 8];
         end
         half = flip ? yo / 2 : xo / 2;
         modifier = lo ? MOD_LARGE[row_sel[half]] : MOD_SMALL[row_sel[half]];
         if (hi) begin
            modifier = -modifier;
         end
         px = int'(blk.block_col) * 4 + xo;
         py = int'(blk.block_row) * 4 + yo;
         if (px >= wlim || py >= hlim) begin
            continue;
         end
         for (int ch = 0; ch < 3; ch++) begin
            level = int'(base[half][ch]) + modifier;
            if (level < 0) begin
               level = 0;
            end else if (level > 255) begin
               level = 255;
            end
            chan[ch] = 8'(level);
         end
         pix.pixel_x = 12'(px);
         pix.pixel_y = 12'(py);
         pix.red     = chan[0];
         pix.green   = chan[1];
         pix.blue    = chan[2];
         pix.last    = 1'b0;
         pending_pixels.push_back(pix);
         emitted++;
      end
      if (emitted > 0) begin
         pending_pixels[pending_pixels.size() - 1].last = 1'b1;
      end
   endfunction

   // One register access: a setup cycle, then an access cycle that ends at
   // the edge where pready is high. A read is checked against the size that
   // the block should hold. Called and left just after a falling edge.
   task automatic csr_access(input csr_index_type idx, input logic wr, input logic [31:0] data);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = wr;
      paddr   = {idx, 2'b00};
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (wr) begin
         if (idx == CSR_IMAGE_WIDTH) begin
            image_w = data[12:0];
         end else begin
            image_h = data[12:0];
         end
      end else if (prdata != {19'd0, (idx == CSR_IMAGE_WIDTH) ? image_w : image_h}) begin
         flag_mismatch($sformatf("register %s read back %0d, expected %0d", idx.name(),
                                 prdata, (idx == CSR_IMAGE_WIDTH) ? image_w : image_h));
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // Reprograms the image size once the block has gone quiet: every owed
   // pixel has come out, and the settle time of SETTLE_CYCLES has passed with
   // start held low.
   task automatic set_image(input logic [31:0] w, input logic [31:0] h);
      start = 1'b0;
      while (pending_pixels.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_access(CSR_IMAGE_WIDTH, 1'b1, w);
      csr_access(CSR_IMAGE_HEIGHT, 1'b1, h);
      csr_access(CSR_IMAGE_WIDTH, 1'b0, 32'd0);
      csr_access(CSR_IMAGE_HEIGHT, 1'b0, 32'd0);
   endtask

   // Offers one request after a random gap and waits until it is taken. The
   // request stays on the port on return, so the caller either replaces it
   // or lowers start at that same falling edge.
   task automatic send_block(input req_type blk, input int gap_pct, input logic typed,
                             input int typed_n, input logic [23:0] typed_rgb);
      int first;
      while ($urandom_range(0, 99) < gap_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start    = 1'b1;
      req_data = blk;
      do @(posedge clock); while (busy);
      first = pending_pixels.size();
      decode_block(blk);
      if (typed) begin
         if (pending_pixels.size() - first != typed_n) begin
            flag_mismatch($sformatf("block %h at (%0d,%0d): %0d pixels predicted, %0d typed",
                                    blk.block_word, blk.block_col, blk.block_row,
                                    pending_pixels.size() - first, typed_n));
         end
         for (int i = first; i < pending_pixels.size(); i++) begin
            {pending_pixels[i].red, pending_pixels[i].green, pending_pixels[i].blue} = typed_rgb;
         end
      end
      @(negedge clock);
   endtask

   // Random block coordinate: anywhere, near the origin, or around the image
   // edge so that partial blocks are common.
   function automatic logic [9:0] pick_coord(input int lim);
      int c;
      case ($urandom_range(0, 3))
         0: c = $urandom_range(0, 1023);
         1: c = $urandom_range(0, 3);
         default: c = lim / 4 + int'($urandom_range(0, 2)) - 1;
      endcase
      if (c < 0) begin
         c = 0;
      end else if (c > 1023) begin
         c = 1023;
      end
      return 10'(c);
   endfunction

   // Every pixel the block emits must match the oldest owed pixel. The
   // receiver cannot stall, so each strobe is one pixel taken.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_pixels.size() == 0) begin
            flag_mismatch($sformatf("unexpected pixel x=%0d y=%0d rgb=%02h%02h%02h last=%0b",
                                    rsp_data.pixel_x, rsp_data.pixel_y, rsp_data.red,
                                    rsp_data.green, rsp_data.blue, rsp_data.last));
         end else begin
            if (rsp_data.pixel_x != pending_pixels[0].pixel_x
                  || rsp_data.pixel_y != pending_pixels[0].pixel_y
                  || rsp_data.red != pending_pixels[0].red
                  || rsp_data.green != pending_pixels[0].green
                  || rsp_data.blue != pending_pixels[0].blue
                  || rsp_data.last != pending_pixels[0].last) begin
               flag_mismatch($sformatf({"pixel mismatch: expected x=%0d y=%0d ",
                                        "rgb=%02h%02h%02h last=%0b, got x=%0d y=%0d ",
                                        "rgb=%02h%02h%02h last=%0b"},
                                       pending_pixels[0].pixel_x, pending_pixels[0].pixel_y,
                                       pending_pixels[0].red, pending_pixels[0].green,
                                       pending_pixels[0].blue, pending_pixels[0].last,
                                       rsp_data.pixel_x, rsp_data.pixel_y, rsp_data.red,
                                       rsp_data.green, rsp_data.blue, rsp_data.last));
            end
            void'(pending_pixels.pop_front());
         end
      end
   end

   // Hang detection: any accepted request, emitted pixel or register access
   // restarts the count.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe || (psel && penable)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("[etc1_block_decoder_unit] ERROR");
      $finish;
   end

   initial begin : stimulus
      req_type blk;
      int      sent;
      int      gap_pct;
      int      wlim;
      int      hlim;

      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      image_w        = DimReset;
      image_h        = DimReset;
      mismatch_count = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Both registers must come out of reset at the largest image size.
      csr_access(CSR_IMAGE_WIDTH, 1'b0, 32'd0);
      csr_access(CSR_IMAGE_HEIGHT, 1'b0, 32'd0);

      // Directed part: extremes of colour, clamping in both directions,
      // wrapping differential bases, both split directions, and images that
      // cut blocks or hide them completely.
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         if (DIRECTED[i].new_size) begin
            set_image(DIRECTED[i].size_w, DIRECTED[i].size_h);
         end
         blk.block_word = DIRECTED[i].word;
         blk.block_col  = DIRECTED[i].col;
         blk.block_row  = DIRECTED[i].row;
         send_block(blk, 11, DIRECTED[i].typed, DIRECTED[i].n_pix, DIRECTED[i].rgb);
      end

      // Random part: a series of image sizes, each with a burst of random
      // blocks. The sender idles often at first, then very often, then never.
      sent = 0;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         set_image(PHASE_W[ph], PHASE_H[ph]);
         wlim = (image_w > 13'd4096) ? 4096 : int'(image_w);
         hlim = (image_h > 13'd4096) ? 4096 : int'(image_h);
         for (int k = 0; k < PHASE_N[ph]; k++) begin
            blk.block_word = {$urandom, $urandom};
            blk.block_col  = pick_coord(wlim);
            blk.block_row  = pick_coord(hlim);
            gap_pct = (sent < 69) ? 11 : (sent < 139) ? 52 : 0;
            send_block(blk, gap_pct, 1'b0, 0, 24'h0);
            sent++;
         end
      end
      start = 1'b0;

      // Let every owed pixel arrive, then watch a while longer for strays.
      while (pending_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[etc1_block_decoder_unit] OK");
      end else begin
         $display("[etc1_block_decoder_unit] ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/etc1bd_pkg.sv
rtl/etc1bd_front.sv
rtl/etc1bd_queue.sv
rtl/etc1bd_back.sv
rtl/etc1_block_decoder_unit.sv
test/tb_etc1_block_decoder_unit.sv
